FILE: rtl/mclm_pkg.sv
// ----------------------------------------------------------------------------
// mclm_pkg: shared types and constants of the controller-learn mapper
// Item formats, mode codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mclm_pkg;

  localparam int NUM_CONTROLLERS_DEF = 128;
  localparam int MAX_PARAMS_DEF      = 256;

  localparam logic [8:0] PARAM_COUNT_RST = 9'd256;

  typedef enum logic [2:0] {
    MODE_CC          = 3'd0,
    MODE_ARM         = 3'd1,
    MODE_CANCEL      = 3'd2,
    MODE_COMMIT      = 3'd3,
    MODE_CLEAR_PARAM = 3'd4,
    MODE_CLEAR_ALL   = 3'd5,
    MODE_QUERY_CC    = 3'd6,
    MODE_QUERY_PARAM = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] controller;
    logic [6:0] cc_value;
    logic [7:0] param_sel;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  target_param;
    logic        target_valid;
    logic [15:0] norm_value;
    logic [6:0]  found_cc;
    logic        found_valid;
    logic        armed_flag;
    logic [7:0]  learning_index;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the accepted item, restart the sweep
    logic rd_single;  // read the entry of the item's controller
    logic rd_sweep;   // read the entry at the sweep counter
    logic finish;     // apply state updates and hand over the result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic read_req;
    logic sweep_req;
    logic cnt_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/midi_cc_learn_mapper.sv
// ----------------------------------------------------------------------------
// midi_cc_learn_mapper: MIDI controller-learn mapper, top level
// Maps controller numbers to parameter indices with learn, clear and query.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input item gives exactly one result item. Items are handled one at a
// time by a sequencer. Arm, cancel and clear all go from decode straight to
// the final step; controller messages and parameter queries with a
// controller in range read the table once in between; and commit, clear
// param and controller queries sweep every table entry through the single
// read port of the index memory, one entry per cycle, and then a drain step.
// A commit with nothing to commit, and a clear param or controller query
// whose parameter index is out of range, skip the sweep. The finished
// result sits in an output register, so a new item is accepted while the
// previous result still waits to be taken; the block only holds in its
// final step when that register is still full. The table's valid flags are
// cleared directly at reset, so no clearing pass is needed and the block
// accepts items right away. The param_count register may be written at any
// time the block is idle; cfg_ready is always high.

module midi_cc_learn_mapper #(
  parameter int NUM_CONTROLLERS = mclm_pkg::NUM_CONTROLLERS_DEF,
  parameter int MAX_PARAMS      = mclm_pkg::MAX_PARAMS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire mclm_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      mclm_pkg::out_item_t out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [8:0]          cfg_data
);
  import mclm_pkg::*;

  logic [8:0] param_count_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       out_free;
  dp_cmd_t    cmd;
  dp_status_t st;
  out_item_t  res;

  // The configuration register needs no back-pressure.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_count_r <= PARAM_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      param_count_r <= cfg_data;
    end
  end

  // The output register is free when empty or when its item leaves now.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mclm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  mclm_datapath #(
    .NUM_CONTROLLERS (NUM_CONTROLLERS),
    .MAX_PARAMS      (MAX_PARAMS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .param_count (param_count_r),
    .cmd         (cmd),
    .st          (st),
    .res         (res)
  );

endmodule

`default_nettype wire

FILE: rtl/mclm_ctrl.sv
// ----------------------------------------------------------------------------
// mclm_ctrl: sequencer of the controller-learn mapper
// Steps each item through decode, a single read or a full table sweep if
// needed, and the final update that hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mclm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic                out_free,
  input  wire mclm_pkg::dp_status_t st,
  output      mclm_pkg::dp_cmd_t   cmd
);
  import mclm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_READ   = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (st.read_req) begin
          state_nxt = S_READ;
        end else if (st.sweep_req) begin
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        cmd.rd_single = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_SWEEP: begin
        cmd.rd_sweep = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mclm_datapath.sv
// ----------------------------------------------------------------------------
// mclm_datapath: mapping table, learn state and result forming
// Holds the controller table (index memory plus per-entry valid flops), the
// sweep counter and compare stage, and the learn registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mclm_datapath #(
  parameter int NUM_CONTROLLERS = mclm_pkg::NUM_CONTROLLERS_DEF,
  parameter int MAX_PARAMS      = mclm_pkg::MAX_PARAMS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mclm_pkg::in_item_t   in_data,
  input  wire logic [8:0]           param_count,
  input  wire mclm_pkg::dp_cmd_t    cmd,
  output      mclm_pkg::dp_status_t st,
  output      mclm_pkg::out_item_t  res
);
  import mclm_pkg::*;

  localparam int CW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam logic [8:0] MAX_LIM = (MAX_PARAMS > 511) ? 9'd511 : 9'(MAX_PARAMS);
  localparam logic [CW-1:0] LAST_ADDR = CW'(NUM_CONTROLLERS - 1);

  // value * 65535 / 127, floored: 65535 = 127 * 516 + 3.
  function automatic logic [15:0] norm_q16(input logic [6:0] v);
    logic [8:0]  v3;
    logic [15:0] base;
    logic [1:0]  q;
    v3   = 9'(v) * 9'd3;
    base = 16'(v) * 16'd516;
    if (v3 >= 9'd381) begin
      q = 2'd3;
    end else if (v3 >= 9'd254) begin
      q = 2'd2;
    end else if (v3 >= 9'd127) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return base + 16'(q);
  endfunction

  in_item_t item_r;

  logic [7:0]    idx_mem [NUM_CONTROLLERS];
  logic [NUM_CONTROLLERS-1:0] vld_r;

  logic [CW-1:0] cnt_r;
  logic [7:0]    rd_idx_r;
  logic          rd_vld_r;
  logic          cmp_pend_r;
  logic [CW-1:0] cmp_addr_r;
  logic          found_r;
  logic [CW-1:0] found_cc_r;

  logic          armed_r, armed_nxt;
  logic [7:0]    target_r, target_nxt;
  logic          capv_r, capv_nxt;
  logic [CW-1:0] capc_r, capc_nxt;

  logic [8:0]    lim;
  logic          ctl_ok, sel_ok, idx_ok;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic [7:0]    key;
  logic          match;
  logic          commit_ok;
  logic          wr_en;

  assign lim    = (param_count > MAX_LIM) ? MAX_LIM : param_count;
  assign ctl_ok = ({1'b0, item_r.controller} < 8'(NUM_CONTROLLERS));
  assign sel_ok = ({1'b0, item_r.param_sel} < lim);
  assign idx_ok = rd_vld_r && ({1'b0, rd_idx_r} < lim);

  assign commit_ok = armed_r && capv_r;
  assign wr_en     = cmd.finish && (item_r.mode == MODE_COMMIT) && commit_ok;

  assign st.read_req  = ((item_r.mode == MODE_CC) || (item_r.mode == MODE_QUERY_PARAM))
                        && ctl_ok;
  assign st.sweep_req = ((item_r.mode == MODE_COMMIT) && commit_ok) ||
                        (((item_r.mode == MODE_CLEAR_PARAM) ||
                          (item_r.mode == MODE_QUERY_CC)) && sel_ok);
  assign st.cnt_last  = (cnt_r == LAST_ADDR);

  assign rd_en   = cmd.rd_single || cmd.rd_sweep;
  assign rd_addr = cmd.rd_sweep ? cnt_r : item_r.controller[CW-1:0];
  assign key     = (item_r.mode == MODE_COMMIT) ? target_r : item_r.param_sel;
  assign match   = cmp_pend_r && rd_vld_r && (rd_idx_r == key);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Index memory: one read port, one write port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r <= idx_mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
    if (wr_en) begin
      idx_mem[capc_r] <= target_r;
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr_r <= cnt_r;
    if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.rd_sweep) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_pend_r <= 1'b0;
      vld_r      <= '0;
      found_r    <= 1'b0;
    end else begin
      cmp_pend_r <= cmd.rd_sweep;
      if (cmd.finish && (item_r.mode == MODE_CLEAR_ALL)) begin
        vld_r <= '0;
      end else begin
        if (match && (item_r.mode != MODE_QUERY_CC)) begin
          vld_r[cmp_addr_r] <= 1'b0;
        end
        if (wr_en) begin
          vld_r[capc_r] <= 1'b1;
        end
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (match && (item_r.mode == MODE_QUERY_CC) && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match && !found_r) begin
      found_cc_r <= cmp_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      target_r <= '0;
      capv_r   <= 1'b0;
      capc_r   <= '0;
    end else if (cmd.finish) begin
      armed_r  <= armed_nxt;
      target_r <= target_nxt;
      capv_r   <= capv_nxt;
      capc_r   <= capc_nxt;
    end
  end

  always_comb begin
    armed_nxt  = armed_r;
    target_nxt = target_r;
    capv_nxt   = capv_r;
    capc_nxt   = capc_r;
    res        = '0;
    unique case (item_r.mode)
      MODE_CC: begin
        if (ctl_ok) begin
          if (armed_r) begin
            capv_nxt     = 1'b1;
            capc_nxt     = item_r.controller[CW-1:0];
            res.accepted = 1'b1;
          end else if (idx_ok) begin
            res.accepted     = 1'b1;
            res.target_param = rd_idx_r;
            res.target_valid = 1'b1;
            res.norm_value   = norm_q16(item_r.cc_value);
          end
        end
      end
      MODE_ARM: begin
        if (sel_ok) begin
          capv_nxt     = 1'b0;
          target_nxt   = item_r.param_sel;
          armed_nxt    = 1'b1;
          res.accepted = 1'b1;
        end
      end
      MODE_CANCEL: begin
        armed_nxt  = 1'b0;
        target_nxt = '0;
        capv_nxt   = 1'b0;
      end
      MODE_COMMIT: begin
        if (commit_ok) begin
          armed_nxt    = 1'b0;
          target_nxt   = '0;
          capv_nxt     = 1'b0;
          res.accepted = 1'b1;
        end
      end
      MODE_CLEAR_PARAM, MODE_CLEAR_ALL: begin
        // Table updates only; learn state is left alone.
      end
      MODE_QUERY_CC: begin
        res.found_valid = found_r;
        res.found_cc    = found_r ? 7'(found_cc_r) : 7'd0;
      end
      MODE_QUERY_PARAM: begin
        if (ctl_ok && idx_ok) begin
          res.target_param = rd_idx_r;
          res.target_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.armed_flag     = armed_nxt;
    res.learning_index = armed_nxt ? target_nxt : 8'd0;
  end

endmodule

`default_nettype wire
